>>> rtl/bpfa_pkg.sv
// bpfa_pkg: shared types and constants of the bitmap page frame allocator.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package bpfa_pkg;

    localparam int FN_W      = 12;    // frame_number / result_frame
    localparam int CNT_W     = 13;    // frame_count
    localparam int LIM_W     = 13;    // frame_limit register
    localparam int CMD_W     = 2;
    localparam int STAT_W    = 2;
    localparam int APB_DW    = 32;
    localparam int APB_AW    = 3;

    localparam logic [LIM_W-1:0] LIM_RESET = 13'd4096;
    localparam logic [LIM_W-1:0] LIM_MAX   = 13'h1FFF;

    // register index, taken from paddr[2]
    localparam logic REG_FRAME_LIMIT = 1'b0;

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC   = 2'd0,
        CMD_FREE    = 2'd1,
        CMD_RESERVE = 2'd2
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        WR_ZERO,
        WR_ONES,
        WR_SET,
        WR_CLR
    } t_wr_mode;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_SCAN_RD,
        S_SCAN,
        S_ALLOC_WR,
        S_POS_MUL,
        S_POS_FIX,
        S_RUN_STEP,
        S_RUN_WR,
        S_RESP
    } t_state;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic [FN_W-1:0]  frame_number;
        logic [CNT_W-1:0] frame_count;
    } t_in_item;

    typedef struct packed {
        logic [FN_W-1:0]   result_frame;
        logic [STAT_W-1:0] status;
    } t_out_item;

    // controller -> datapath
    typedef struct packed {
        logic     load_item;  // capture the accepted item
        logic     ptr_clr;    // restart the scan pointer
        logic     rd_scan;    // read word at scan pointer, advance pointer
        logic     rd_idx;     // read word at current index
        logic     wr_en;
        t_wr_mode wr_mode;
        logic     scan_hit;   // latch lowest free bit of the read word
        logic     pos_mul;    // word index estimate
        logic     pos_fix;    // correct estimate, load run
        logic     run_adv;    // step run to the next word
        logic     idx_inc;    // clearing pass
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             fnum_ok;
        logic             run_ok;
        logic             cnt_zero;
        logic             word_full;
        logic             idx_last;
        logic             frame_ok;
        logic             mask_full;
        logic             run_last;
    } t_dp_stat;

    // controller -> result register
    typedef struct packed {
        logic    load;
        logic    frame_en;
        t_status code;
    } t_res_ctl;

endpackage

`default_nettype wire

>>> rtl/bpfa_datapath.sv
// bpfa_datapath: bitmap memory, scan pointer, frame position and run masks.
// Depends on bpfa_pkg; driven by bpfa_ctrl through t_dp_cmd.
`timescale 1ns / 1ps
`default_nettype none

module bpfa_datapath
    import bpfa_pkg::*;
#(
    parameter int FRAMES    = 4096,
    parameter int WORD_BITS = 32
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_in_item         i_item,
    input  wire logic [LIM_W-1:0] i_limit,
    input  wire t_dp_cmd          i_cmd,
    output t_dp_stat              o_stat,
    output logic [FN_W-1:0]       o_frame
);

    localparam int NWORDS = (FRAMES + WORD_BITS - 1) / WORD_BITS;
    localparam int AW     = (NWORDS > 1) ? $clog2(NWORDS) : 1;
    localparam int PW     = $clog2(NWORDS + 1);
    localparam int BW     = $clog2(WORD_BITS);
    localparam int NW     = BW + 1;
    localparam int EW     = BW + 2;
    localparam int FRW    = $clog2(NWORDS * WORD_BITS);
    localparam int CW     = ((FRW > LIM_W) ? FRW : LIM_W) + 1;
    // reciprocal for frame / WORD_BITS; estimate is exact or one low
    localparam int PS     = FN_W + 1;
    localparam int RECIP  = (1 << PS) / WORD_BITS;
    localparam int RW     = $clog2(RECIP + 1);
    localparam int PRW    = FN_W + RW;

    logic [WORD_BITS-1:0] r_mem [NWORDS];
    logic [WORD_BITS-1:0] r_rd_data;

    logic [CMD_W-1:0] r_cmd;
    logic [FN_W-1:0]  r_fnum;
    logic [CNT_W-1:0] r_cnt;
    logic [PW-1:0]    r_ptr;
    logic [AW-1:0]    r_idx;
    logic [BW-1:0]    r_bit;
    logic [CNT_W-1:0] r_remain;
    logic [FN_W-1:0]  r_q;

    logic [AW-1:0]        rd_addr;
    logic [WORD_BITS-1:0] wr_data;
    logic [WORD_BITS-1:0] mask;
    logic [NW-1:0]        avail;
    logic [NW-1:0]        n_take;
    logic [CW-1:0]        frame_w;
    logic [PRW-1:0]       prod;
    logic [FN_W-1:0]      rem_raw;
    logic [FN_W-1:0]      q_fix;
    logic [FN_W-1:0]      rem_fix;

    // lowest clear bit: isolate it, then encode the one-hot
    function automatic logic [BW-1:0] low_zero(input logic [WORD_BITS-1:0] w);
        logic [WORD_BITS-1:0] iso;
        logic [BW-1:0]        pos;
        iso = ~w & (w + 1'b1);
        pos = '0;
        for (int b = 0; b < WORD_BITS; b++) begin
            if (iso[b]) begin
                pos = pos | BW'(b);
            end
        end
        return pos;
    endfunction

    assign rd_addr = i_cmd.rd_scan ? r_ptr[AW-1:0] : r_idx;

    // frames taken from the current word: min(bits left in word, frames left)
    assign avail  = NW'(WORD_BITS) - NW'(r_bit);
    assign n_take = (CNT_W'(avail) < r_remain) ? avail : r_remain[NW-1:0];

    always_comb begin
        for (int b = 0; b < WORD_BITS; b++) begin
            mask[b] = (EW'(b) >= EW'(r_bit)) && (EW'(b) < EW'(r_bit) + EW'(n_take));
        end
    end

    always_comb begin
        case (i_cmd.wr_mode)
            WR_ZERO: wr_data = '0;
            WR_ONES: wr_data = '1;
            WR_SET:  wr_data = r_rd_data | mask;
            WR_CLR:  wr_data = r_rd_data & ~mask;
            default: wr_data = r_rd_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[r_idx] <= wr_data;
        end
        if (i_cmd.rd_scan || i_cmd.rd_idx) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // position: frame_number -> word index and bit offset
    assign prod    = PRW'(r_fnum) * PRW'(RECIP);
    assign rem_raw = r_fnum - FN_W'(r_q * FN_W'(WORD_BITS));
    assign q_fix   = (rem_raw >= FN_W'(WORD_BITS)) ? r_q + 1'b1 : r_q;
    assign rem_fix = (rem_raw >= FN_W'(WORD_BITS)) ? rem_raw - FN_W'(WORD_BITS)
                                                   : rem_raw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr <= '0;
            r_idx <= '0;
        end else begin
            if (i_cmd.ptr_clr) begin
                r_ptr <= '0;
            end else if (i_cmd.rd_scan) begin
                r_ptr <= r_ptr + 1'b1;
            end
            if (i_cmd.rd_scan) begin
                r_idx <= r_ptr[AW-1:0];
            end else if (i_cmd.pos_fix) begin
                r_idx <= AW'(q_fix);
            end else if (i_cmd.run_adv || i_cmd.idx_inc) begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_cmd  <= i_item.command;
            r_fnum <= i_item.frame_number;
            r_cnt  <= i_item.frame_count;
        end
        if (i_cmd.pos_mul) begin
            r_q <= FN_W'(prod >> PS);
        end
        if (i_cmd.scan_hit) begin
            r_bit    <= low_zero(r_rd_data);
            r_remain <= CNT_W'(1);
        end else if (i_cmd.pos_fix) begin
            r_bit    <= BW'(rem_fix);
            r_remain <= (r_cmd == CMD_FREE) ? CNT_W'(1) : r_cnt;
        end else if (i_cmd.run_adv) begin
            r_bit    <= '0;
            r_remain <= r_remain - CNT_W'(n_take);
        end
    end

    assign frame_w = CW'(r_idx) * CW'(WORD_BITS) + CW'(r_bit);
    assign o_frame = frame_w[FN_W-1:0];

    always_comb begin
        o_stat.cmd       = r_cmd;
        o_stat.fnum_ok   = LIM_W'(r_fnum) < i_limit;
        o_stat.run_ok    = (LIM_W'(r_fnum) < i_limit)
                        && ((14'(r_fnum) + 14'(r_cnt)) <= 14'(i_limit));
        o_stat.cnt_zero  = (r_cnt == '0);
        o_stat.word_full = (r_rd_data == '1);
        o_stat.idx_last  = (r_idx == AW'(NWORDS - 1));
        o_stat.frame_ok  = frame_w < CW'(i_limit);
        o_stat.mask_full = (mask == '1);
        o_stat.run_last  = (r_remain == CNT_W'(n_take));
    end

endmodule

`default_nettype wire

>>> rtl/bpfa_ctrl.sv
// bpfa_ctrl: command sequencer of the allocator (clear, scan, position, run).
// Depends on bpfa_pkg; drives bpfa_datapath and the result register.
`timescale 1ns / 1ps
`default_nettype none

module bpfa_ctrl
    import bpfa_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    input  wire logic     i_out_ready,
    input  wire t_dp_stat i_stat,
    output logic          o_in_stall,
    output t_dp_cmd       o_cmd,
    output t_res_ctl      o_res
);

    t_state  r_state, n_state;
    t_status r_code, n_code;
    logic    r_frame_en, n_frame_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_code     <= ST_OK;
            r_frame_en <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_code     <= n_code;
            r_frame_en <= n_frame_en;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_code     = r_code;
        n_frame_en = r_frame_en;
        o_cmd      = '0;
        o_cmd.wr_mode = WR_ZERO;
        o_res.load     = 1'b0;
        o_res.frame_en = r_frame_en;
        o_res.code     = r_code;
        o_in_stall = (r_state != S_IDLE);

        case (r_state)
            S_CLEAR: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_mode = WR_ZERO;
                o_cmd.idx_inc = 1'b1;
                if (i_stat.idx_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_frame_en = 1'b0;
                n_code     = ST_OK;
                case (i_stat.cmd)
                    CMD_ALLOC: begin
                        o_cmd.ptr_clr = 1'b1;
                        n_state = S_SCAN_RD;
                    end
                    CMD_FREE: begin
                        if (i_stat.fnum_ok) begin
                            n_state = S_POS_MUL;
                        end else begin
                            n_code  = ST_RANGE;
                            n_state = S_RESP;
                        end
                    end
                    CMD_RESERVE: begin
                        if (!i_stat.run_ok) begin
                            n_code  = ST_RANGE;
                            n_state = S_RESP;
                        end else if (i_stat.cnt_zero) begin
                            n_state = S_RESP;
                        end else begin
                            n_state = S_POS_MUL;
                        end
                    end
                    default: begin
                        n_code  = ST_RANGE;
                        n_state = S_RESP;
                    end
                endcase
            end
            S_SCAN_RD: begin
                o_cmd.rd_scan = 1'b1;
                n_state = S_SCAN;
            end
            S_SCAN: begin
                if (!i_stat.word_full) begin
                    o_cmd.scan_hit = 1'b1;
                    n_state = S_ALLOC_WR;
                end else if (i_stat.idx_last) begin
                    n_code  = ST_FULL;
                    n_state = S_RESP;
                end else begin
                    o_cmd.rd_scan = 1'b1;
                end
            end
            S_ALLOC_WR: begin
                // lowest free frame may still sit at or above the limit
                if (i_stat.frame_ok) begin
                    o_cmd.wr_en   = 1'b1;
                    o_cmd.wr_mode = WR_SET;
                    n_frame_en    = 1'b1;
                end else begin
                    n_code = ST_FULL;
                end
                n_state = S_RESP;
            end
            S_POS_MUL: begin
                o_cmd.pos_mul = 1'b1;
                n_state = S_POS_FIX;
            end
            S_POS_FIX: begin
                o_cmd.pos_fix = 1'b1;
                n_state = S_RUN_STEP;
            end
            S_RUN_STEP: begin
                // whole word covered: write without reading
                if (i_stat.mask_full && (i_stat.cmd == CMD_RESERVE)) begin
                    o_cmd.wr_en   = 1'b1;
                    o_cmd.wr_mode = WR_ONES;
                    o_cmd.run_adv = 1'b1;
                    if (i_stat.run_last) begin
                        n_state = S_RESP;
                    end
                end else begin
                    o_cmd.rd_idx = 1'b1;
                    n_state = S_RUN_WR;
                end
            end
            S_RUN_WR: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_mode = (i_stat.cmd == CMD_FREE) ? WR_CLR : WR_SET;
                o_cmd.run_adv = 1'b1;
                n_state = i_stat.run_last ? S_RESP : S_RUN_STEP;
            end
            S_RESP: begin
                if (i_out_ready) begin
                    o_res.load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    a_accept_decodes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_item |=> (r_state == S_DECODE))
        else $error("accepted item not decoded next cycle");

    a_one_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.rd_scan, o_cmd.rd_idx}))
        else $error("two read sources in one cycle");

    a_frame_ok_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.load && o_res.frame_en) |-> (o_res.code == ST_OK))
        else $error("frame returned with failing status");

endmodule

`default_nettype wire

>>> rtl/bitmap_page_frame_allocator.sv
// bitmap_page_frame_allocator: top level, APB register, result register.
// Depends on bpfa_pkg, bpfa_ctrl and bpfa_datapath.
`timescale 1ns / 1ps
`default_nettype none

//  channel   direction  handshake                  payload
//  in        input      i_in_valid / o_in_stall    i_in_item  (t_in_item)
//  out       output     o_out_valid / i_out_stall  o_out_item (t_out_item)
//  cfg       input      APB psel/penable/pwrite    pwdata -> frame_limit
//
//  Steps between decode and response (NWORDS = FRAMES / WORD_BITS words):
//    allocate: scan up to the first non-full word, at most NWORDS (128 by default)
//              words, one word a cycle from the bitmap RAM; write if in range.
//    free: position, read, write. reserve: position, full words written,
//    partial words read and written. out of range / bad command: none.
//  Reset: a clearing pass writes every bitmap word, input stalled.
//  A finished result waits in the output register; the next item is taken
//  meanwhile, and its own result waits for the register to empty.

module bitmap_page_frame_allocator
    import bpfa_pkg::*;
#(
    parameter int FRAMES    = 4096,
    parameter int WORD_BITS = 32
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // item in
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire t_in_item          i_in_item,
    // result out
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output t_out_item              o_out_item,
    // APB configuration
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0]      prdata,
    output logic                   pready
);

    // limit clamp: frames beyond FRAMES do not exist
    localparam logic [LIM_W-1:0] LIM_CAP =
        (FRAMES > int'(LIM_MAX)) ? LIM_MAX : LIM_W'(FRAMES);

    logic [LIM_W-1:0] r_limit;
    logic [LIM_W-1:0] eff_limit;
    logic             r_out_valid;
    t_out_item        r_out_item;
    logic             out_ready;
    logic             cfg_wr;

    t_dp_cmd          dp_cmd;
    t_dp_stat         dp_stat;
    t_res_ctl         res;
    logic [FN_W-1:0]  dp_frame;

    // APB: zero wait states, single register at index REG_FRAME_LIMIT
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == REG_FRAME_LIMIT)
                  ? {{(APB_DW-LIM_W){1'b0}}, r_limit} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIM_RESET;
        end else if (cfg_wr && (paddr[2] == REG_FRAME_LIMIT)) begin
            r_limit <= pwdata[LIM_W-1:0];
        end
    end

    assign eff_limit = (r_limit > LIM_CAP) ? LIM_CAP : r_limit;

    bpfa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_ready (out_ready),
        .i_stat      (dp_stat),
        .o_in_stall  (o_in_stall),
        .o_cmd       (dp_cmd),
        .o_res       (res)
    );

    bpfa_datapath #(
        .FRAMES    (FRAMES),
        .WORD_BITS (WORD_BITS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_in_item),
        .i_limit (eff_limit),
        .i_cmd   (dp_cmd),
        .o_stat  (dp_stat),
        .o_frame (dp_frame)
    );

    // output register: free when empty or being taken this cycle
    assign out_ready = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res.load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res.load) begin
            r_out_item.result_frame <= res.frame_en ? dp_frame : '0;
            r_out_item.status       <= res.code;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |-> !res.load)
        else $error("pending result overwritten");

endmodule

`default_nettype wire
